@@ hdl/dst_pkg.sv @@
// Package of shared types, constants and register codes for the differential steering PWM drive.
package dst_pkg;

    // Field and register widths.
    localparam int SAMPLE_BITS = 12;
    localparam int PERIOD_W    = 16;
    localparam int DUTY_W      = 16;
    localparam int DIST_W      = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int STEER_W     = 2;
    // The divider lanes take a divisor wide enough for a sample or a period.
    localparam int DIVISOR_W   = 16;

    // Reset values of the configuration registers.
    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST  = PERIOD_W'(12000);
    localparam logic [DIST_W-1:0]   DIST_CONST_RST  = DIST_W'(114251);
    localparam logic [DIST_W-1:0]   DEAD_BAND_RST   = DIST_W'(10);
    localparam logic [DUTY_W-1:0]   DUTY_HIGH_RST   = DUTY_W'(8200);
    localparam logic [DUTY_W-1:0]   DUTY_LOW_RST    = DUTY_W'(3800);
    localparam logic [DUTY_W-1:0]   DUTY_CENTER_RST = DUTY_W'(6000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_CONST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CENTER = 3'd5;

    // Steering codes.
    localparam logic [STEER_W-1:0] STEER_STRAIGHT  = 2'd0;
    localparam logic [STEER_W-1:0] STEER_RIGHT_FAR = 2'd1;
    localparam logic [STEER_W-1:0] STEER_LEFT_FAR  = 2'd2;

    // Command codes.
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic                   cmd;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic [SAMPLE_BITS-1:0] left_sample;
    } in_t;

    typedef struct packed {
        logic               right_drive;
        logic               left_drive;
        logic [STEER_W-1:0] steer;
    } out_t;

    // Configuration as seen by the steering decision.
    typedef struct packed {
        logic [DIST_W-1:0] dead_band;
        logic [DUTY_W-1:0] duty_high;
        logic [DUTY_W-1:0] duty_low;
        logic [DUTY_W-1:0] duty_center;
    } steer_cfg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

@@ hdl/dst_div_lane.sv @@
// Restoring divider lane that produces one quotient bit per clock cycle.
module dst_div_lane #(
    parameter int DIVIDEND_W = dst_pkg::DIST_W,
    parameter int DIVISOR_W  = dst_pkg::DIVISOR_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One restoring step: shift in the next dividend bit and try a subtraction.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    // Next-value logic for the datapath and the step counter.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/dst_steer_merge.sv @@
// Merging stage that compares the two lane distances and holds the steering and duty state.
module dst_steer_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        update,
    input  logic [dst_pkg::DIST_W-1:0]  right_dist,
    input  logic [dst_pkg::DIST_W-1:0]  left_dist,
    input  dst_pkg::steer_cfg_t         cfg,
    output logic [dst_pkg::DUTY_W-1:0]  right_duty,
    output logic [dst_pkg::DUTY_W-1:0]  left_duty,
    output logic [dst_pkg::STEER_W-1:0] steer
);
    import dst_pkg::*;

    logic signed [DIST_W:0] diff;
    logic signed [DIST_W:0] band;
    logic                   far_right;
    logic                   far_left;

    logic [DUTY_W-1:0]  right_duty_reg, right_duty_next;
    logic [DUTY_W-1:0]  left_duty_reg, left_duty_next;
    logic [STEER_W-1:0] steer_reg, steer_next;

    // Signed distance difference against the dead band on either side.
    always_comb
    begin
        diff      = $signed({1'b0, right_dist}) - $signed({1'b0, left_dist});
        band      = $signed({1'b0, cfg.dead_band});
        far_right = (diff > band);
        far_left  = (diff < -band);
    end

    // Steering choice and duties for the new sample.
    always_comb
    begin
        right_duty_next = right_duty_reg;
        left_duty_next  = left_duty_reg;
        steer_next      = steer_reg;
        if (update)
        begin
            if (far_right)
            begin
                steer_next      = STEER_RIGHT_FAR;
                right_duty_next = cfg.duty_high;
                left_duty_next  = cfg.duty_low;
            end
            else if (far_left)
            begin
                steer_next      = STEER_LEFT_FAR;
                right_duty_next = cfg.duty_low;
                left_duty_next  = cfg.duty_high;
            end
            else
            begin
                steer_next      = STEER_STRAIGHT;
                right_duty_next = cfg.duty_center;
                left_duty_next  = cfg.duty_center;
            end
        end
    end

    // Both duties start at zero so that the motors stay off until the first sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_duty_reg <= '0;
            left_duty_reg  <= '0;
            steer_reg      <= STEER_STRAIGHT;
        end
        else
        begin
            right_duty_reg <= right_duty_next;
            left_duty_reg  <= left_duty_next;
            steer_reg      <= steer_next;
        end
    end

    assign right_duty = right_duty_reg;
    assign left_duty  = left_duty_reg;
    assign steer      = steer_reg;

endmodule

@@ hdl/differential_steer_pwm.sv @@
// Top level of the two-motor PWM drive steered by two distance sensors.
// A sample transaction (cmd 1) carries a right and a left converter reading; two divider
// lanes turn them into distances in parallel (constant / reading, zero read as one), and
// the merging stage picks the steering choice and the two duties. A tick transaction
// (cmd 0) advances the wrapping PWM period counter. Each transaction gives exactly one
// result: the two drive levels and the steering choice. A sample, or a tick that finds the
// counter at or beyond a lowered period (reduced through the same lane), waits in the
// divide state while the restoring divider lanes produce one quotient bit per cycle over
// 20 bits; other ticks go straight to the finish state. A new transaction is taken once the
// previous one has moved into the output register, even while that result still waits.
// Configuration writes are to be taken only while idle; the block does not enforce this.
module differential_steer_pwm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dst_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dst_pkg::out_t                 out_data,
    input  logic                          cfg_we,
    input  logic [dst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dst_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dst_pkg::*;

    // Configuration registers.
    logic [PERIOD_W-1:0] pwm_period_reg;
    logic [DIST_W-1:0]   dist_const_reg;
    logic [DIST_W-1:0]   dead_band_reg;
    logic [DUTY_W-1:0]   duty_high_reg;
    logic [DUTY_W-1:0]   duty_low_reg;
    logic [DUTY_W-1:0]   duty_center_reg;

    // Sequencer and counter state.
    state_t              state_reg, state_next;
    logic                is_tick_reg, is_tick_next;
    logic [PERIOD_W-1:0] count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;

    // Control decoded from the state.
    logic                accept;
    logic                out_free;
    logic                start_right;
    logic                start_left;
    logic                commit;
    logic                emit;

    // Lane signals.
    logic [DIST_W-1:0]    right_dividend;
    logic [DIVISOR_W-1:0] right_divisor;
    logic [DIVISOR_W-1:0] left_divisor;
    logic                 right_busy, right_done;
    logic                 left_busy, left_done;
    logic [DIST_W-1:0]    right_quo, left_quo;
    logic [DIVISOR_W-1:0] right_rem, left_rem;

    // Tick arithmetic.
    logic [PERIOD_W-1:0]  period_eff;
    logic [PERIOD_W:0]    count_inc;
    logic                 tick_fast;
    logic [SAMPLE_BITS-1:0] right_reading;
    logic [SAMPLE_BITS-1:0] left_reading;

    // Merge outputs.
    steer_cfg_t          steer_cfg;
    logic [DUTY_W-1:0]   right_duty;
    logic [DUTY_W-1:0]   left_duty;
    logic [STEER_W-1:0]  steer;

    // Configuration write decoder; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg  <= PWM_PERIOD_RST;
            dist_const_reg  <= DIST_CONST_RST;
            dead_band_reg   <= DEAD_BAND_RST;
            duty_high_reg   <= DUTY_HIGH_RST;
            duty_low_reg    <= DUTY_LOW_RST;
            duty_center_reg <= DUTY_CENTER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PWM_PERIOD:  pwm_period_reg  <= cfg_data[PERIOD_W-1:0];
                REG_DIST_CONST:  dist_const_reg  <= cfg_data[DIST_W-1:0];
                REG_DEAD_BAND:   dead_band_reg   <= cfg_data[DIST_W-1:0];
                REG_DUTY_HIGH:   duty_high_reg   <= cfg_data[DUTY_W-1:0];
                REG_DUTY_LOW:    duty_low_reg    <= cfg_data[DUTY_W-1:0];
                REG_DUTY_CENTER: duty_center_reg <= cfg_data[DUTY_W-1:0];
                default:         ;
            endcase
        end
    end

    // Period counter step: a zero period acts as one; the fast path covers the usual
    // increment and wrap, the divider lane handles a counter at or beyond a lowered period.
    always_comb
    begin
        period_eff    = (pwm_period_reg == '0) ? PERIOD_W'(1) : pwm_period_reg;
        count_inc     = {1'b0, count_reg} + 1'b1;
        tick_fast     = (count_inc <= {1'b0, period_eff});
        right_reading = (in_data.right_sample == '0) ? SAMPLE_BITS'(1) : in_data.right_sample;
        left_reading  = (in_data.left_sample == '0) ? SAMPLE_BITS'(1) : in_data.left_sample;
    end

    // Lane operands: a sample divides the constant by each reading, a slow tick reduces the
    // incremented counter modulo the period in the right lane.
    always_comb
    begin
        if (in_data.cmd == CMD_SAMPLE)
        begin
            right_dividend = dist_const_reg;
            right_divisor  = DIVISOR_W'(right_reading);
        end
        else
        begin
            right_dividend = DIST_W'(count_inc);
            right_divisor  = DIVISOR_W'(period_eff);
        end
        left_divisor = DIVISOR_W'(left_reading);
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.cmd == CMD_TICK && tick_fast)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (right_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        in_ready    = 1'b0;
        start_right = 1'b0;
        start_left  = 1'b0;
        commit      = 1'b0;
        emit        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                start_right = in_valid && !(in_data.cmd == CMD_TICK && tick_fast);
                start_left  = in_valid && (in_data.cmd == CMD_SAMPLE);
            end
            ST_DIV:
            begin
                commit = right_done;
            end
            ST_FINISH:
            begin
                emit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Counter, transaction kind and output register.
    always_comb
    begin
        is_tick_next   = is_tick_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            is_tick_next = (in_data.cmd == CMD_TICK);
            if (in_data.cmd == CMD_TICK && tick_fast)
            begin
                count_next = (count_inc == {1'b0, period_eff}) ? '0 : count_inc[PERIOD_W-1:0];
            end
        end
        if (commit && is_tick_reg)
        begin
            count_next = right_rem[PERIOD_W-1:0];
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.right_drive = (count_reg < right_duty);
            out_data_next.left_drive  = (count_reg < left_duty);
            out_data_next.steer       = steer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            is_tick_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            is_tick_reg   <= is_tick_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Right divider lane, shared with the period reduction.
    dst_div_lane #(
        .DIVIDEND_W (DIST_W),
        .DIVISOR_W  (DIVISOR_W)
    ) u_right_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_right),
        .dividend  (right_dividend),
        .divisor   (right_divisor),
        .busy      (right_busy),
        .done      (right_done),
        .quotient  (right_quo),
        .remainder (right_rem)
    );

    // Left divider lane.
    dst_div_lane #(
        .DIVIDEND_W (DIST_W),
        .DIVISOR_W  (DIVISOR_W)
    ) u_left_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_left),
        .dividend  (dist_const_reg),
        .divisor   (left_divisor),
        .busy      (left_busy),
        .done      (left_done),
        .quotient  (left_quo),
        .remainder (left_rem)
    );

    // Merging stage.
    always_comb
    begin
        steer_cfg.dead_band   = dead_band_reg;
        steer_cfg.duty_high   = duty_high_reg;
        steer_cfg.duty_low    = duty_low_reg;
        steer_cfg.duty_center = duty_center_reg;
    end

    dst_steer_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (commit && !is_tick_reg),
        .right_dist (right_quo),
        .left_dist  (left_quo),
        .cfg        (steer_cfg),
        .right_duty (right_duty),
        .left_duty  (left_duty),
        .steer      (steer)
    );

    // The left lane only runs alongside the right lane, so it finishes in step with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        left_done |-> right_done)
        else $error("left lane finished without the right lane");

    // No new transaction is taken while a lane is still dividing.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!right_busy && !left_busy))
        else $error("input ready while a divider lane is busy");

    // After a tick the counter lies below the effective period.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && is_tick_reg) |-> (count_reg < period_eff))
        else $error("period counter out of range after a tick");

    // The steering choice never takes the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (steer == STEER_STRAIGHT || steer == STEER_RIGHT_FAR || steer == STEER_LEFT_FAR))
        else $error("steering choice holds an unused code");

    // The left remainder lies below the divisor, so it never exceeds a reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        left_done |-> ((left_rem >> SAMPLE_BITS) == '0))
        else $error("left lane remainder beyond the reading range");

endmodule
